/* rtl/spq_pkg.sv */
// Package for the sorted priority queue: payload structs, entry layout,
// operation and status codes, and the controller/datapath command types.
// No dependencies.
`default_nettype none

package spq_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 16;

    // Operation codes carried in the opcode field.
    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_ENQUEUED = 2'd0;
    localparam logic [1:0] ST_DEQUEUED = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    // Read address selection for the entry memory.
    localparam logic [1:0] RD_FRONT = 2'd0;
    localparam logic [1:0] RD_TAIL  = 2'd1;
    localparam logic [1:0] RD_NEXT  = 2'd2;

    localparam int ENTRY_W = 48;

    typedef struct packed {
        logic               opcode;
        logic signed [31:0] item_value;
        logic        [15:0] item_priority;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] out_value;
        logic        [1:0]  status;
    } t_out_item;

    typedef struct packed {
        logic signed [31:0] value;
        logic        [15:0] prio;
    } t_entry;

    typedef struct packed {
        logic       load;
        logic [1:0] rd_sel;
        logic       shift;
        logic       place_next;
        logic       place_zero;
        logic       pop;
        logic       set_res;
        logic [1:0] res_code;
        logic       emit;
    } t_dp_cmd;

    typedef struct packed {
        logic cnt_zero;
        logic cnt_full;
        logic idx_zero;
        logic lower;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

/* rtl/spq_ram.sv */
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none

module spq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/spq_ctrl.sv */
// Controller state machine of the sorted priority queue.
// Depends on spq_pkg for the command and status structs and the codes.
`default_nettype none

module spq_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire logic            i_opcode,
    output logic                 o_in_ready,
    input  wire spq_pkg::t_dp_sts i_sts,
    output spq_pkg::t_dp_cmd     o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ENQ    = 3'd1;
    localparam logic [2:0] S_PLACE0 = 3'd2;
    localparam logic [2:0] S_DEQ    = 3'd3;
    localparam logic [2:0] S_RESP   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_opcode == spq_pkg::OP_ENQUEUE) begin
                        if (i_sts.cnt_full) begin
                            o_cmd.set_res  = 1'b1;
                            o_cmd.res_code = spq_pkg::ST_FULL;
                            n_state        = S_RESP;
                        end else if (i_sts.cnt_zero) begin
                            n_state = S_PLACE0;
                        end else begin
                            o_cmd.rd_sel = spq_pkg::RD_TAIL;
                            n_state      = S_ENQ;
                        end
                    end else begin
                        if (i_sts.cnt_zero) begin
                            o_cmd.set_res  = 1'b1;
                            o_cmd.res_code = spq_pkg::ST_EMPTY;
                            n_state        = S_RESP;
                        end else begin
                            o_cmd.rd_sel = spq_pkg::RD_FRONT;
                            n_state      = S_DEQ;
                        end
                    end
                end
            end
            S_ENQ: begin
                // Walk from the tail toward the front, moving each lower entry down.
                if (i_sts.lower) begin
                    o_cmd.shift = 1'b1;
                    if (i_sts.idx_zero) begin
                        n_state = S_PLACE0;
                    end else begin
                        o_cmd.rd_sel = spq_pkg::RD_NEXT;
                    end
                end else begin
                    o_cmd.place_next = 1'b1;
                    o_cmd.set_res    = 1'b1;
                    o_cmd.res_code   = spq_pkg::ST_ENQUEUED;
                    n_state          = S_RESP;
                end
            end
            S_PLACE0: begin
                o_cmd.place_zero = 1'b1;
                o_cmd.set_res    = 1'b1;
                o_cmd.res_code   = spq_pkg::ST_ENQUEUED;
                n_state          = S_RESP;
            end
            S_DEQ: begin
                o_cmd.pop      = 1'b1;
                o_cmd.set_res  = 1'b1;
                o_cmd.res_code = spq_pkg::ST_DEQUEUED;
                n_state        = S_RESP;
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

`default_nettype wire

/* rtl/spq_dp.sv */
// Datapath of the sorted priority queue: entry memory kept as a ring,
// head and count registers, walk index, result and output registers.
// Depends on spq_pkg and spq_ram.
`default_nettype none

module spq_dp #(
    parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire spq_pkg::t_in_item i_in_item,
    input  wire spq_pkg::t_dp_cmd  i_cmd,
    output spq_pkg::t_dp_sts       o_sts,
    input  wire logic              i_out_ready,
    output logic                   o_out_valid,
    output spq_pkg::t_out_item     o_out_item
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW:0]   DEPTH_W = (AW+1)'(QUEUE_DEPTH);
    localparam logic [AW-1:0] LAST    = AW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_C  = CW'(QUEUE_DEPTH);

    // Maps a position counted from the front onto a memory address.
    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] head,
                                             input logic [CW-1:0] lidx);
        logic [AW:0] sum;
        sum = (AW+1)'(head) + (AW+1)'(lidx);
        if (sum >= DEPTH_W) begin
            sum = sum - DEPTH_W;
        end
        return sum[AW-1:0];
    endfunction

    logic [AW-1:0]       r_head;
    logic [CW-1:0]       r_count;
    logic [AW-1:0]       r_idx;
    spq_pkg::t_entry     r_item;
    spq_pkg::t_out_item  r_res;
    spq_pkg::t_out_item  r_out;
    logic                r_out_valid;

    logic [CW-1:0]       tail_l;
    logic [CW-1:0]       next_l;
    logic [CW-1:0]       below_l;
    logic [AW-1:0]       raddr;
    logic                we;
    logic [AW-1:0]       waddr;
    spq_pkg::t_entry     wdata;
    logic [spq_pkg::ENTRY_W-1:0] rdata_raw;
    spq_pkg::t_entry     rdata;

    assign tail_l  = r_count - CW'(1);
    assign next_l  = CW'(r_idx) - CW'(1);
    assign below_l = CW'(r_idx) + CW'(1);
    assign rdata   = spq_pkg::t_entry'(rdata_raw);

    always_comb begin
        unique case (i_cmd.rd_sel)
            spq_pkg::RD_FRONT: raddr = r_head;
            spq_pkg::RD_TAIL:  raddr = f_phys(r_head, tail_l);
            spq_pkg::RD_NEXT:  raddr = f_phys(r_head, next_l);
            default:           raddr = r_head;
        endcase
    end

    always_comb begin
        we    = i_cmd.shift | i_cmd.place_next | i_cmd.place_zero;
        waddr = i_cmd.place_zero ? r_head : f_phys(r_head, below_l);
        wdata = i_cmd.shift ? rdata : r_item;
    end

    spq_ram #(
        .WIDTH (spq_pkg::ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata_raw)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.place_next || i_cmd.place_zero) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.pop) begin
                r_count <= r_count - CW'(1);
                r_head  <= (r_head == LAST) ? '0 : r_head + AW'(1);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item.value <= i_in_item.item_value;
            r_item.prio  <= i_in_item.item_priority;
            r_idx        <= tail_l[AW-1:0];
        end else if (i_cmd.shift) begin
            r_idx <= r_idx - AW'(1);
        end
        if (i_cmd.set_res) begin
            r_res.status    <= i_cmd.res_code;
            r_res.out_value <= i_cmd.pop ? rdata.value : 32'sd0;
        end
        if (i_cmd.emit) begin
            r_out <= r_res;
        end
    end

    assign o_sts.cnt_zero = (r_count == '0);
    assign o_sts.cnt_full = (r_count == FULL_C);
    assign o_sts.idx_zero = (r_idx == '0);
    assign o_sts.lower    = (rdata.prio < r_item.prio);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_C)
        else $error("entry count exceeds the queue depth");

    a_no_write_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.place_next || i_cmd.place_zero || i_cmd.shift) |-> !o_sts.cnt_full)
        else $error("entry written while the queue is full");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> !o_sts.cnt_zero)
        else $error("pop issued on an empty queue");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || i_out_ready))
        else $error("result emitted over an untaken transaction");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.place_next || i_cmd.place_zero) |=> r_count == $past(r_count) + CW'(1))
        else $error("entry count did not follow an insertion");
`endif

endmodule

`default_nettype wire

/* rtl/sorted_priority_queue_core.sv */
// Top level of the sorted priority queue: joins the controller and datapath.
// Depends on spq_pkg, spq_ctrl, spq_dp (and spq_ram below it).
//
//   Channel   Valid        Ready        Payload                Direction
//   input     i_in_valid   o_in_ready   i_in_item  (t_in_item)  in
//   output    o_out_valid  i_out_ready  o_out_item (t_out_item) out
//
// Each input transaction yields exactly one output transaction. An enqueue
// into a nonempty queue goes from idle to the walk state, which moves each entry
// of lower priority down, then to the result state, with the place-zero state
// between them if the new entry lands at the front; an enqueue into an empty
// queue uses place-zero, a dequeue the pop state, a full or empty refusal
// neither; each walk step uses the entry memory's single read and write port.
// Reset (synchronous, active low) empties the queue at once; no clearing pass
// is needed since only entries below the count are ever read.
// A finished result waits in the output register while the next input
// transaction is already taken; a stalled output holds only the result step.
`default_nettype none

module sorted_priority_queue_core #(
    parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire spq_pkg::t_in_item i_in_item,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output spq_pkg::t_out_item     o_out_item
);

    // Command and status buses between the controller and the datapath.
    spq_pkg::t_dp_cmd cmd;
    spq_pkg::t_dp_sts sts;

    // The controller sequences each transaction: it decides between the
    // insertion walk, the front pop and the full or empty refusals.
    spq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_in_item.opcode),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // The datapath keeps the entries in a ring memory ordered from the head,
    // so a dequeue only advances the head while an enqueue walks up from the tail.
    spq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire
